// ===== sv/fnm_pkg.sv =====
package fnm_pkg;

  localparam int unsigned MEAN_BITS = 24;
  localparam int unsigned POS_BITS  = 8;
  localparam int unsigned CFG_BITS  = 9;
  localparam int unsigned SIDE_MIN  = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_GATHER,
    ST_FLUSH,
    ST_DLOAD,
    ST_DIV,
    ST_LATCH,
    ST_OUT,
    ST_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    RES_A,
    RES_B,
    RES_C
  } res_e;

  typedef struct packed {
    logic       accept;
    logic       cfg_wr;
    logic       init;
    logic       gather;
    logic [1:0] slot;
    res_e       res;
    logic       div_load;
    logic       div_step;
    logic       out_load;
    logic       commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    logic has_c;
    logic div_last;
  } ctrl_sts_t;

endpackage

// ===== sv/fnm_ifs.sv =====
interface fnm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fnm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fnm_pkg::MEAN_BITS-1:0]  mean_q8;
  logic        [fnm_pkg::POS_BITS-1:0]   out_row;
  logic        [fnm_pkg::POS_BITS-1:0]   out_col;
  logic                                  run_last;
  logic                                  frame_end;

  modport source (output valid, output mean_q8, output out_row, output out_col,
                  output run_last, output frame_end, input ready);
  modport sink   (input valid, input mean_q8, input out_row, input out_col,
                  input run_last, input frame_end, output ready);
endinterface

interface fnm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fnm_pkg::CFG_BITS-1:0]   side_length;

  modport source (output valid, output side_length, input ready);
  modport sink   (input valid, input side_length, output ready);
endinterface

// ===== sv/fnm_ctrl.sv =====
module fnm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  fnm_pkg::ctrl_sts_t sts_i,
  output fnm_pkg::ctrl_cmd_t cmd_o
);
  import fnm_pkg::*;

  state_e     state_q, state_d;
  res_e       res_q, res_d;
  logic [1:0] slot_q, slot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= RES_A;
      slot_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      slot_q  <= slot_d;
    end
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    slot_d  = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !cfg_valid_i) begin
          state_d = ST_INIT;
          if (sts_i.has_a) begin
            res_d = RES_A;
          end else if (sts_i.has_b) begin
            res_d = RES_B;
          end else if (sts_i.has_c) begin
            res_d = RES_C;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_INIT: begin
        slot_d  = 2'd0;
        state_d = ST_GATHER;
      end
      ST_GATHER: begin
        slot_d = slot_q + 2'd1;
        if (slot_q == 2'd2) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH:  state_d = ST_DLOAD;
      ST_DLOAD:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_LATCH;
        end
      end
      ST_LATCH:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_COMMIT;
          case (res_q)
            RES_A: begin
              if (sts_i.has_b) begin
                res_d   = RES_B;
                state_d = ST_INIT;
              end else if (sts_i.has_c) begin
                res_d   = RES_C;
                state_d = ST_INIT;
              end
            end
            RES_B: begin
              if (sts_i.has_c) begin
                res_d   = RES_C;
                state_d = ST_INIT;
              end
            end
            default: state_d = ST_COMMIT;
          endcase
        end
      end
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE) && !cfg_valid_i;
    cfg_ready_o    = (state_q == ST_IDLE);
    out_valid_o    = (state_q == ST_OUT);
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i && !cfg_valid_i;
    cmd_o.cfg_wr   = (state_q == ST_IDLE) && cfg_valid_i;
    cmd_o.init     = (state_q == ST_INIT);
    cmd_o.gather   = (state_q == ST_GATHER);
    cmd_o.slot     = slot_q;
    cmd_o.res      = res_q;
    cmd_o.div_load = (state_q == ST_DLOAD);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = (state_q == ST_LATCH);
    cmd_o.commit   = (state_q == ST_COMMIT);
  end

endmodule

// ===== sv/fnm_dpath.sv =====
module fnm_dpath #(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fnm_pkg::ctrl_cmd_t                   cmd_i,
  output fnm_pkg::ctrl_sts_t                   sts_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic [fnm_pkg::CFG_BITS-1:0]         cfg_data_i,
  output logic signed [fnm_pkg::MEAN_BITS-1:0] mean_q8_o,
  output logic [fnm_pkg::POS_BITS-1:0]         out_row_o,
  output logic [fnm_pkg::POS_BITS-1:0]         out_col_o,
  output logic                                 run_last_o,
  output logic                                 frame_end_o
);
  import fnm_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SIDE);
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW     = IDX_W + 1;
  localparam int unsigned KW     = (CFG_BITS > SIDE_W) ? CFG_BITS : SIDE_W;
  localparam int unsigned SUM_W  = SAMPLE_BITS + 2;
  localparam int unsigned XW     = SUM_W + FRAC_BITS + 1;
  localparam int unsigned DCW    = $clog2(XW + 1);
  localparam int unsigned QW     = (XW > MEAN_BITS) ? XW : MEAN_BITS;
  localparam int unsigned PW     = (IDX_W > POS_BITS) ? IDX_W : POS_BITS;

  logic [SIDE_W-1:0]             side_q;
  logic [IDX_W-1:0]              row_q, col_q;
  logic signed [SAMPLE_BITS-1:0] smp_q, prev_q, rd_q;
  logic signed [SAMPLE_BITS-1:0] mem [2**ADDR_W];
  logic signed [SUM_W-1:0]       acc_q;
  logic [2:0]                    cnt_q;
  logic                          pend_q;
  logic [XW-1:0]                 dvd_q;
  logic [2:0]                    rem_q;
  logic [3:0]                    dsr_q;
  logic [DCW-1:0]                dcnt_q;
  logic                          neg_q;

  logic [CW-1:0]                 nw, cw, rw;
  logic                          last_row, last_col;
  logic [IDX_W-1:0]              c_m1, c_p1, c_m2;
  logic                          rp, rd_en;
  logic [ADDR_W-1:0]             rd_addr, wr_addr;
  logic [KW-1:0]                 cfg_w;
  logic [SIDE_W-1:0]             side_new;
  logic [SUM_W-1:0]              mag;
  logic [3:0]                    trial;
  logic                          ge;
  logic [QW-1:0]                 q_ext, mean_full;
  logic [PW-1:0]                 row_w, col_w;
  logic                          last_w;

  assign nw       = CW'(side_q);
  assign cw       = CW'(col_q);
  assign rw       = CW'(row_q);
  assign last_row = (rw + CW'(1)) == nw;
  assign last_col = (cw + CW'(1)) == nw;
  assign c_m1     = col_q - IDX_W'(1);
  assign c_p1     = col_q + IDX_W'(1);
  assign c_m2     = col_q - IDX_W'(2);
  assign rp       = row_q[0];
  assign wr_addr  = {rp, col_q};

  assign sts_o.has_a    = (row_q != '0);
  assign sts_o.has_b    = last_row && (col_q != '0);
  assign sts_o.has_c    = last_row && last_col;
  assign sts_o.div_last = (dcnt_q == DCW'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {rp, col_q};
    case (cmd_i.res)
      RES_A: begin
        case (cmd_i.slot)
          2'd0: begin
            rd_en   = (rw >= CW'(2));
            rd_addr = {rp, col_q};
          end
          2'd1: begin
            rd_en   = (col_q != '0);
            rd_addr = {~rp, c_m1};
          end
          2'd2: begin
            rd_en   = (cw + CW'(1)) < nw;
            rd_addr = {~rp, c_p1};
          end
          default: rd_en = 1'b0;
        endcase
      end
      RES_B: begin
        case (cmd_i.slot)
          2'd0: begin
            rd_en   = 1'b1;
            rd_addr = {~rp, c_m1};
          end
          2'd1: begin
            rd_en   = (cw >= CW'(2));
            rd_addr = {rp, c_m2};
          end
          default: rd_en = 1'b0;
        endcase
      end
      RES_C: begin
        rd_en   = (cmd_i.slot == 2'd0);
        rd_addr = {~rp, col_q};
      end
      default: rd_en = 1'b0;
    endcase
    rd_en = rd_en && cmd_i.gather;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem[wr_addr] <= smp_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    cfg_w = KW'(cfg_data_i);
    if (cfg_w < KW'(SIDE_MIN)) begin
      side_new = SIDE_W'(SIDE_MIN);
    end else if (cfg_w > KW'(MAX_SIDE)) begin
      side_new = SIDE_W'(MAX_SIDE);
    end else begin
      side_new = SIDE_W'(cfg_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_W'(SIDE_MIN);
      row_q  <= '0;
      col_q  <= '0;
      pend_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      pend_q <= rd_en;
      if (cmd_i.cfg_wr) begin
        side_q <= side_new;
        row_q  <= '0;
        col_q  <= '0;
      end else if (cmd_i.commit) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + IDX_W'(1);
        end else begin
          col_q <= c_p1;
        end
      end
      if (cmd_i.div_load) begin
        dcnt_q <= DCW'(XW);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - DCW'(1);
      end
    end
  end

  assign mag   = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
  assign trial = {rem_q, dvd_q[XW-1]};
  assign ge    = (trial >= dsr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q <= sample_i;
    end
    if (cmd_i.commit) begin
      prev_q <= smp_q;
    end
    if (cmd_i.init) begin
      acc_q <= (cmd_i.res == RES_C) ? SUM_W'(prev_q) : SUM_W'(smp_q);
      cnt_q <= 3'd1;
    end else if (pend_q) begin
      acc_q <= acc_q + SUM_W'(rd_q);
      cnt_q <= cnt_q + 3'd1;
    end
    if (cmd_i.div_load) begin
      neg_q <= acc_q[SUM_W-1];
      dvd_q <= (XW'(mag) << (FRAC_BITS + 1)) + XW'(cnt_q);
      rem_q <= 3'd0;
      dsr_q <= {cnt_q, 1'b0};
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[XW-2:0], ge};
      rem_q <= ge ? 3'(trial - dsr_q) : trial[2:0];
    end
  end

  assign q_ext     = QW'(dvd_q);
  assign mean_full = neg_q ? (~q_ext + QW'(1)) : q_ext;

  always_comb begin
    case (cmd_i.res)
      RES_A: begin
        row_w  = PW'(row_q - IDX_W'(1));
        col_w  = PW'(col_q);
        last_w = !(sts_o.has_b || sts_o.has_c);
      end
      RES_B: begin
        row_w  = PW'(row_q);
        col_w  = PW'(c_m1);
        last_w = !sts_o.has_c;
      end
      default: begin
        row_w  = PW'(row_q);
        col_w  = PW'(col_q);
        last_w = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_q8_o   <= mean_full[MEAN_BITS-1:0];
      out_row_o   <= row_w[POS_BITS-1:0];
      out_col_o   <= col_w[POS_BITS-1:0];
      run_last_o  <= last_w;
      frame_end_o <= (cmd_i.res == RES_C);
    end
  end

endmodule

// ===== sv/four_neighbour_mean_filter.sv =====
// Channel  Direction  Word                                          Handshake
// smp_i    in         sample                                        valid/ready
// res_o    out        mean_q8, out_row, out_col, run_last, frame_end valid/ready
// cfg_i    in         side_length                                   valid/ready
//
// An input word completes k (0 to 3) results, and each mean is formed by a
// bit-serial division that yields XW = SAMPLE_BITS + FRAC_BITS + 3 quotient bits;
// the line store, with a read port apart from its write port, supplies
// one neighbour per cycle. The input is ready only between words.
// Reset restores a side of two and the first image position; the line store is
// not cleared. A stalled result holds the block until it is taken.
module four_neighbour_mean_filter #(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fnm_in_if.sink           smp_i,
  fnm_out_if.source        res_o,
  fnm_cfg_if.sink          cfg_i
);
  import fnm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  fnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (smp_i.valid),
    .in_ready_o  (smp_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fnm_dpath #(
    .MAX_SIDE    (MAX_SIDE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (smp_i.sample),
    .cfg_data_i  (cfg_i.side_length),
    .mean_q8_o   (res_o.mean_q8),
    .out_row_o   (res_o.out_row),
    .out_col_o   (res_o.out_col),
    .run_last_o  (res_o.run_last),
    .frame_end_o (res_o.frame_end)
  );

endmodule

// ===== sv/fnm_checks.sv =====
module fnm_checks (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [fnm_pkg::MEAN_BITS-1:0] mean_q8_i,
  input logic                                 run_last_i,
  input logic                                 frame_end_i
);

  // The block works on one word at a time, so a pending result means no new input.
  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready straight after an accepted word");

  a_frame_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && frame_end_i) |-> run_last_i)
    else $error("frame end on a result that is not the last of its word");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(mean_q8_i)))
    else $error("stalled result changed");

endmodule

bind four_neighbour_mean_filter fnm_checks u_fnm_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .mean_q8_i   (res_o.mean_q8),
  .run_last_i  (res_o.run_last),
  .frame_end_i (res_o.frame_end)
);
